/* sv/lsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the least-squares line fit block.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned MAX_POINTS_DEF    = 4096;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned DIGIT_W           = 16;
  localparam int unsigned QUOT_W            = 33;

  localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic               last_point;
  } req_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic               degenerate;
    logic               saturated;
  } rsp_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MSET  = 8'b0000_0010,
    ST_MSTEP = 8'b0000_0100,
    ST_MFIN  = 8'b0000_1000,
    ST_DSET  = 8'b0001_0000,
    ST_DSTEP = 8'b0010_0000,
    ST_DFIN  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } back_state_e;

endpackage
`default_nettype wire

/* sv/lsf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_front
// Point accumulator: squares and cross products registered, then summed.
// The closing point of a set pushes the finished sums into the queue.
// ----------------------------------------------------------------------------
module lsf_front #(
  parameter int unsigned MAX_POINTS = lsf_pkg::MAX_POINTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  lsf_pkg::req_t req_i,
  output logic          pend_o,
  output logic          push_o,
  output logic [1 + $clog2(MAX_POINTS + 1) + 2 * (17 + $clog2(MAX_POINTS))
                + (31 + $clog2(MAX_POINTS)) + (32 + $clog2(MAX_POINTS)) - 1:0] entry_o
);

  localparam int unsigned LOGM = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned SXW  = 17 + LOGM;
  localparam int unsigned SQW  = 31 + LOGM;
  localparam int unsigned SPW  = 32 + LOGM;

  logic                  s1_vld_q, s1_last_q;
  logic signed [15:0]    s1_x_q, s1_y_q;
  logic [30:0]           s1_xx_q;
  logic signed [31:0]    s1_xy_q;
  logic signed [31:0]    xx_full, xy_full;

  logic [CW-1:0]         cnt_q, cnt_d;
  logic signed [SXW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [SQW-1:0]        sxx_q, sxx_d;
  logic signed [SPW-1:0] sxy_q, sxy_d;
  logic                  ovf_q, ovf_d;
  logic                  room;

  assign xx_full = req_i.x_sample * req_i.x_sample;
  assign xy_full = req_i.x_sample * req_i.y_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept_i;
      s1_last_q <= accept_i & req_i.last_point;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_x_q  <= req_i.x_sample;
      s1_y_q  <= req_i.y_sample;
      s1_xx_q <= xx_full[30:0];
      s1_xy_q <= xy_full;
    end
  end

  assign room = cnt_q < CW'(MAX_POINTS);

  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxx_d = sxx_q;
    sxy_d = sxy_q;
    ovf_d = ovf_q;
    if (s1_vld_q) begin
      if (room) begin
        cnt_d = cnt_q + 1'b1;
        sx_d  = sx_q + SXW'(s1_x_q);
        sy_d  = sy_q + SXW'(s1_y_q);
        sxx_d = sxx_q + SQW'(s1_xx_q);
        sxy_d = sxy_q + SPW'(s1_xy_q);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign push_o  = s1_vld_q & s1_last_q;
  assign pend_o  = s1_last_q;
  assign entry_o = {ovf_d, cnt_d, sx_d, sy_d, sxx_d, sxy_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (push_o) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sxx_q <= sxx_d;
      sxy_q <= sxy_d;
      ovf_q <= ovf_d;
    end
  end

endmodule
`default_nettype wire

/* sv/lsf_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_fifo
// Short queue of finished point sets between accumulator and solver.
// ----------------------------------------------------------------------------
module lsf_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = lsf_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [W-1:0]                 data_i,
  input  logic                         pop_i,
  output logic [W-1:0]                 head_o,
  output logic [$clog2(DEPTH + 1)-1:0] count_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != CNTW'(DEPTH))
    else $error("lsf_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("lsf_fifo: pop from empty queue");
`endif

endmodule
`default_nettype wire

/* sv/lsf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_back
// Fit solver: six signed products on a shared 16-bit digit multiplier,
// then two restoring divisions of 33 quotient bits with saturation.
// ----------------------------------------------------------------------------
module lsf_back #(
  parameter int unsigned MAX_POINTS    = lsf_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRACTION_BITS = lsf_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  logic [1 + $clog2(MAX_POINTS + 1) + 2 * (17 + $clog2(MAX_POINTS))
                + (31 + $clog2(MAX_POINTS)) + (32 + $clog2(MAX_POINTS)) - 1:0] entry_i,
  output logic          pop_o,
  output logic          done_o,
  output lsf_pkg::rsp_t rsp_o
);

  localparam int unsigned LOGM = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned SXW  = 17 + LOGM;
  localparam int unsigned SQW  = 31 + LOGM;
  localparam int unsigned SPW  = 32 + LOGM;
  localparam int unsigned MW   = 31 + LOGM;
  localparam int unsigned OW   = MW + 1;
  localparam int unsigned DGW  = lsf_pkg::DIGIT_W;
  localparam int unsigned ND   = (MW + DGW - 1) / DGW;
  localparam int unsigned BW   = ND * DGW;
  localparam int unsigned AW   = MW + BW;
  localparam int unsigned PW   = 2 * MW + 1;
  localparam int unsigned DW   = 2 * MW + 2;
  localparam int unsigned SHW  = DW + FRACTION_BITS;
  localparam int unsigned QW   = lsf_pkg::QUOT_W;
  localparam int unsigned HW   = SHW - QW;
  localparam int unsigned DCW  = $clog2(ND + 1);
  localparam int unsigned QCW  = $clog2(QW + 1);

  localparam logic [2:0] P_N_SXX  = 3'd0;
  localparam logic [2:0] P_SX_SX  = 3'd1;
  localparam logic [2:0] P_N_SXY  = 3'd2;
  localparam logic [2:0] P_SX_SY  = 3'd3;
  localparam logic [2:0] P_SXX_SY = 3'd4;
  localparam logic [2:0] P_SX_SXY = 3'd5;

  localparam logic [QW-1:0] LIM_POS = QW'(lsf_pkg::RES_MAX);
  localparam logic [QW-1:0] LIM_NEG = QW'(lsf_pkg::RES_MIN);

  lsf_pkg::back_state_e state_q, state_d;

  logic                  e_ovf;
  logic [CW-1:0]         e_n;
  logic signed [SXW-1:0] e_sx, e_sy;
  logic [SQW-1:0]        e_sxx;
  logic signed [SPW-1:0] e_sxy;

  logic [2:0]            pidx_q, pidx_d;
  logic [DCW-1:0]        dig_q, dig_d;
  logic [QCW-1:0]        qcnt_q, qcnt_d;
  logic                  dsel_q, dsel_d;

  logic [CW-1:0]         n_q, n_d;
  logic signed [SXW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [SQW-1:0]        sxx_q, sxx_d;
  logic signed [SPW-1:0] sxy_q, sxy_d;
  logic [MW-1:0]         amag_q, amag_d;
  logic [BW-1:0]         bmag_q, bmag_d;
  logic                  psign_q, psign_d;
  logic [AW-1:0]         acc_q, acc_d;
  logic signed [PW-1:0]  pfirst_q, pfirst_d;
  logic signed [DW-1:0]  den_q, den_d, numm_q, numm_d, numb_q, numb_d;
  logic                  neg_q, neg_d;
  logic [DW-1:0]         rem_q, rem_d;
  logic [QW-1:0]         low_q, low_d, quo_q, quo_d;
  logic signed [31:0]    slope_q, slope_d, icept_q, icept_d;
  logic                  degen_q, degen_d, sat_q, sat_d;

  logic signed [OW-1:0]  op_n, op_sx, op_sy, op_sxx, op_sxy, op_a, op_b;
  logic [OW-1:0]         a_abs, b_abs;
  logic [MW+DGW-1:0]     dprod;
  logic [PW-1:0]         pu;
  logic signed [PW-1:0]  pval;
  logic signed [DW-1:0]  pdiff, num_sel;
  logic [DW-1:0]         nmag, den_u;
  logic [SHW-1:0]        shifted;
  logic [HW-1:0]         hi_part;
  logic [DW:0]           rem2;
  logic                  ge;
  logic                  over;
  logic [31:0]           qres;

  assign {e_ovf, e_n, e_sx, e_sy, e_sxx, e_sxy} = entry_i;

  // multiplier operands
  assign op_n   = OW'($signed({1'b0, n_q}));
  assign op_sx  = OW'(sx_q);
  assign op_sy  = OW'(sy_q);
  assign op_sxx = $signed({1'b0, sxx_q});
  assign op_sxy = OW'(sxy_q);

  always_comb begin
    case (pidx_q)
      P_N_SXX:  begin op_a = op_n;   op_b = op_sxx; end
      P_SX_SX:  begin op_a = op_sx;  op_b = op_sx;  end
      P_N_SXY:  begin op_a = op_n;   op_b = op_sxy; end
      P_SX_SY:  begin op_a = op_sx;  op_b = op_sy;  end
      P_SXX_SY: begin op_a = op_sxx; op_b = op_sy;  end
      P_SX_SXY: begin op_a = op_sx;  op_b = op_sxy; end
      default:  begin op_a = '0;     op_b = '0;     end
    endcase
  end

  assign a_abs = op_a[OW-1] ? OW'(-op_a) : OW'(op_a);
  assign b_abs = op_b[OW-1] ? OW'(-op_b) : OW'(op_b);

  assign dprod = amag_q * bmag_q[BW-1 -: DGW];

  assign pu    = {1'b0, acc_q[2*MW-1:0]};
  assign pval  = psign_q ? $signed(-pu) : $signed(pu);
  assign pdiff = DW'(pfirst_q) - DW'(pval);

  // divider
  assign den_u   = den_q;
  assign num_sel = dsel_q ? numb_q : numm_q;
  assign nmag    = num_sel[DW-1] ? DW'(-num_sel) : DW'(num_sel);
  assign shifted = SHW'(nmag) << FRACTION_BITS;
  assign hi_part = shifted[SHW-1:QW];
  assign rem2    = {rem_q, low_q[QW-1]};
  assign ge      = rem2 >= {1'b0, den_u};
  assign over    = neg_q ? (quo_q > LIM_NEG) : (quo_q > LIM_POS);
  assign qres    = over ? (neg_q ? lsf_pkg::RES_MIN : lsf_pkg::RES_MAX)
                        : (neg_q ? -quo_q[31:0] : quo_q[31:0]);

  assign pop_o = (state_q == lsf_pkg::ST_IDLE) && avail_i;

  always_comb begin
    state_d  = state_q;
    pidx_d   = pidx_q;
    dig_d    = dig_q;
    qcnt_d   = qcnt_q;
    dsel_d   = dsel_q;
    n_d      = n_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    sxx_d    = sxx_q;
    sxy_d    = sxy_q;
    amag_d   = amag_q;
    bmag_d   = bmag_q;
    psign_d  = psign_q;
    acc_d    = acc_q;
    pfirst_d = pfirst_q;
    den_d    = den_q;
    numm_d   = numm_q;
    numb_d   = numb_q;
    neg_d    = neg_q;
    rem_d    = rem_q;
    low_d    = low_q;
    quo_d    = quo_q;
    slope_d  = slope_q;
    icept_d  = icept_q;
    degen_d  = degen_q;
    sat_d    = sat_q;
    case (state_q)
      lsf_pkg::ST_IDLE: begin
        if (avail_i) begin
          n_d     = e_n;
          sx_d    = e_sx;
          sy_d    = e_sy;
          sxx_d   = e_sxx;
          sxy_d   = e_sxy;
          sat_d   = e_ovf;
          degen_d = 1'b0;
          slope_d = '0;
          icept_d = '0;
          pidx_d  = P_N_SXX;
          state_d = lsf_pkg::ST_MSET;
        end
      end
      lsf_pkg::ST_MSET: begin
        amag_d  = a_abs[MW-1:0];
        bmag_d  = BW'(b_abs[MW-1:0]);
        psign_d = op_a[OW-1] ^ op_b[OW-1];
        acc_d   = '0;
        dig_d   = DCW'(ND);
        state_d = lsf_pkg::ST_MSTEP;
      end
      lsf_pkg::ST_MSTEP: begin
        acc_d  = (acc_q << DGW) + AW'(dprod);
        bmag_d = bmag_q << DGW;
        dig_d  = dig_q - 1'b1;
        if (dig_q == DCW'(1)) begin
          state_d = lsf_pkg::ST_MFIN;
        end
      end
      lsf_pkg::ST_MFIN: begin
        state_d = lsf_pkg::ST_MSET;
        pidx_d  = pidx_q + 3'd1;
        case (pidx_q)
          P_SX_SX: begin
            den_d = pdiff;
            if (pdiff == '0 || pdiff[DW-1]) begin
              degen_d = 1'b1;
              state_d = lsf_pkg::ST_OUT;
            end
          end
          P_SX_SY:  numm_d = pdiff;
          P_SX_SXY: begin
            numb_d  = pdiff;
            dsel_d  = 1'b0;
            state_d = lsf_pkg::ST_DSET;
          end
          default:  pfirst_d = pval;
        endcase
      end
      lsf_pkg::ST_DSET: begin
        neg_d = num_sel[DW-1];
        if (DW'(hi_part) >= den_u) begin
          quo_d   = '1;
          state_d = lsf_pkg::ST_DFIN;
        end else begin
          rem_d   = DW'(hi_part);
          low_d   = shifted[QW-1:0];
          quo_d   = '0;
          qcnt_d  = QCW'(QW);
          state_d = lsf_pkg::ST_DSTEP;
        end
      end
      lsf_pkg::ST_DSTEP: begin
        rem_d  = ge ? DW'(rem2 - {1'b0, den_u}) : DW'(rem2);
        quo_d  = {quo_q[QW-2:0], ge};
        low_d  = low_q << 1;
        qcnt_d = qcnt_q - 1'b1;
        if (qcnt_q == QCW'(1)) begin
          state_d = lsf_pkg::ST_DFIN;
        end
      end
      lsf_pkg::ST_DFIN: begin
        if (over) begin
          sat_d = 1'b1;
        end
        if (dsel_q) begin
          icept_d = $signed(qres);
          state_d = lsf_pkg::ST_OUT;
        end else begin
          slope_d = $signed(qres);
          dsel_d  = 1'b1;
          state_d = lsf_pkg::ST_DSET;
        end
      end
      lsf_pkg::ST_OUT: begin
        state_d = lsf_pkg::ST_IDLE;
      end
      default: begin
        state_d = lsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsf_pkg::ST_IDLE;
      pidx_q  <= P_N_SXX;
      dig_q   <= '0;
      qcnt_q  <= '0;
      dsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pidx_q  <= pidx_d;
      dig_q   <= dig_d;
      qcnt_q  <= qcnt_d;
      dsel_q  <= dsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    sxx_q    <= sxx_d;
    sxy_q    <= sxy_d;
    amag_q   <= amag_d;
    bmag_q   <= bmag_d;
    psign_q  <= psign_d;
    acc_q    <= acc_d;
    pfirst_q <= pfirst_d;
    den_q    <= den_d;
    numm_q   <= numm_d;
    numb_q   <= numb_d;
    neg_q    <= neg_d;
    rem_q    <= rem_d;
    low_q    <= low_d;
    quo_q    <= quo_d;
    slope_q  <= slope_d;
    icept_q  <= icept_d;
    degen_q  <= degen_d;
    sat_q    <= sat_d;
  end

  assign done_o = (state_q == lsf_pkg::ST_OUT);
  assign rsp_o  = '{slope: slope_q, intercept: icept_q, degenerate: degen_q,
                    saturated: sat_q};

`ifndef SYNTH
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("lsf_back: result strobe longer than one cycle");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.degenerate |-> rsp_o.slope == '0 && rsp_o.intercept == '0)
    else $error("lsf_back: degenerate fit with nonzero result");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lsf_pkg::ST_DSTEP |-> rem_q < den_u)
    else $error("lsf_back: partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

/* sv/least_squares_line_fit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Least-squares straight-line fit over sets of integer points, Q15.16 output.
// Throughput: one point per cycle while busy is low; busy rises only when
//   two finished sets are queued or pending ahead of the solver.
// After the last point is accepted its products are registered, the sums are
//   queued, and the idle solver runs six products on its shared digit
//   multiplier (ND = 3 digits at defaults) and two divisions on its 33-step
//   divider before done_o rises; degenerate sets finish early.
// Reset clears all sums, the queue and the solver; results cannot be stalled.
// ----------------------------------------------------------------------------
module least_squares_line_fit #(
  parameter int unsigned MAX_POINTS    = lsf_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRACTION_BITS = lsf_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lsf_pkg::req_t req_i,
  output logic          done_o,
  output lsf_pkg::rsp_t rsp_o
);

  localparam int unsigned LOGM = $clog2(MAX_POINTS);
  localparam int unsigned EW   = 1 + $clog2(MAX_POINTS + 1) + 2 * (17 + LOGM)
                                 + (31 + LOGM) + (32 + LOGM);
  localparam int unsigned QD   = lsf_pkg::QUEUE_DEPTH;
  localparam int unsigned CNTW = $clog2(QD + 1);
  localparam int unsigned BSW  = CNTW + 1;

  logic            accept;
  logic            pend, push, pop;
  logic [EW-1:0]   entry_in, entry_head;
  logic [CNTW-1:0] q_count;

  assign busy   = (BSW'(q_count) + BSW'(pend)) >= BSW'(QD);
  assign accept = start & ~busy;

  lsf_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (req_i),
    .pend_o  (pend),
    .push_o  (push),
    .entry_o (entry_in)
  );

  lsf_fifo #(
    .W    (EW),
    .DEPTH(QD)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .pop_i  (pop),
    .head_o (entry_head),
    .count_o(q_count)
  );

  lsf_back #(
    .MAX_POINTS   (MAX_POINTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .avail_i(q_count != '0),
    .entry_i(entry_head),
    .pop_o  (pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire
